FILE: rtl/core/csim_pkg.sv
// Shared types and constants for the cosine similarity stream block.
`timescale 1ns / 1ps
`default_nettype none
package csim_pkg;
    localparam int MAX_ELEMENTS = 512;
    localparam int FEAT_W       = 16;
    localparam int CNT_W        = 11;
    localparam int PROD_W       = 32;
    localparam int SQ_W         = 31;
    localparam int DOT_W        = 42;
    localparam int NORM_W       = 41;
    localparam int RAD_W        = 2 * NORM_W;
    localparam int ROOT_W       = NORM_W;
    localparam int REM_W        = ROOT_W + 3;
    localparam int NUM_W        = DOT_W + 15;
    localparam int SQRT_STEPS   = RAD_W / 2;
    localparam int DIV_STEPS    = NUM_W;
    localparam int STEP_W       = 6;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = 2;

    typedef struct packed {
        logic [DOT_W-1:0]  dot;
        logic [NORM_W-1:0] norm_a;
        logic [NORM_W-1:0] norm_b;
        logic              ovf;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
        logic room;
    } t_qstat;
endpackage
`default_nettype wire

FILE: rtl/core/csim_front.sv
// Front end: accepts element pairs, forms products and accumulates per vector.
`timescale 1ns / 1ps
`default_nettype none
module csim_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [csim_pkg::FEAT_W-1:0]  i_feat_a,
    input  wire logic signed [csim_pkg::FEAT_W-1:0]  i_feat_b,
    input  wire logic                                i_last_element,
    input  wire csim_pkg::t_qstat                    i_qstat,
    output logic                                     o_push,
    output csim_pkg::t_job                           o_job
);
    logic                                  w_acc;
    logic                                  w_keep;
    logic [csim_pkg::CNT_W-1:0]            r_count;
    logic                                  r_ovf;
    logic                                  r_s1_valid;
    logic                                  r_s1_last;
    logic                                  r_s1_keep;
    logic                                  r_s1_ovf;
    logic signed [csim_pkg::PROD_W-1:0]    r_pab;
    logic [csim_pkg::SQ_W-1:0]             r_paa;
    logic [csim_pkg::SQ_W-1:0]             r_pbb;
    logic signed [csim_pkg::PROD_W-1:0]    w_paa;
    logic signed [csim_pkg::PROD_W-1:0]    w_pbb;
    logic [csim_pkg::DOT_W-1:0]            r_dot;
    logic [csim_pkg::NORM_W-1:0]           r_na;
    logic [csim_pkg::NORM_W-1:0]           r_nb;
    logic [csim_pkg::DOT_W-1:0]            n_dot;
    logic [csim_pkg::NORM_W-1:0]           n_na;
    logic [csim_pkg::NORM_W-1:0]           n_nb;

    // at most one word in flight behind the queue, so keep one slot spare
    assign o_ready = i_qstat.room;
    assign w_acc   = i_valid && o_ready;
    assign w_keep  = r_count < csim_pkg::CNT_W'(csim_pkg::MAX_ELEMENTS);
    assign w_paa   = i_feat_a * i_feat_a;
    assign w_pbb   = i_feat_b * i_feat_b;

    always_comb begin
        n_dot = r_dot;
        n_na  = r_na;
        n_nb  = r_nb;
        if (r_s1_keep) begin
            n_dot = r_dot + csim_pkg::DOT_W'(r_pab);
            n_na  = r_na + csim_pkg::NORM_W'(r_paa);
            n_nb  = r_nb + csim_pkg::NORM_W'(r_pbb);
        end
    end

    assign o_push        = r_s1_valid && r_s1_last;
    assign o_job.dot     = n_dot;
    assign o_job.norm_a  = n_na;
    assign o_job.norm_b  = n_nb;
    assign o_job.ovf     = r_s1_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s1_keep  <= 1'b0;
            r_s1_ovf   <= 1'b0;
            r_dot      <= '0;
            r_na       <= '0;
            r_nb       <= '0;
        end else begin
            r_s1_valid <= w_acc;
            r_s1_last  <= w_acc && i_last_element;
            r_s1_keep  <= w_acc && w_keep;
            r_s1_ovf   <= r_ovf || !w_keep;
            if (w_acc) begin
                if (i_last_element) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else if (w_keep) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (o_push) begin
                r_dot <= '0;
                r_na  <= '0;
                r_nb  <= '0;
            end else begin
                r_dot <= n_dot;
                r_na  <= n_na;
                r_nb  <= n_nb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pab <= i_feat_a * i_feat_b;
        r_paa <= w_paa[csim_pkg::SQ_W-1:0];
        r_pbb <= w_pbb[csim_pkg::SQ_W-1:0];
    end
endmodule
`default_nettype wire

FILE: rtl/core/csim_queue.sv
// Short queue of finished vector sums between front and back.
`timescale 1ns / 1ps
`default_nettype none
module csim_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire csim_pkg::t_job    i_job,
    input  wire logic              i_pop,
    output csim_pkg::t_job         o_job,
    output csim_pkg::t_qstat       o_qstat
);
    csim_pkg::t_job               r_mem [csim_pkg::Q_DEPTH];
    logic [csim_pkg::Q_AW-1:0]    r_wp;
    logic [csim_pkg::Q_AW-1:0]    r_rp;
    logic [csim_pkg::Q_AW:0]      r_cnt;
    logic                         w_pop;

    assign o_job         = r_mem[r_rp];
    assign o_qstat.empty = r_cnt == '0;
    assign o_qstat.full  = r_cnt == (csim_pkg::Q_AW+1)'(csim_pkg::Q_DEPTH);
    assign o_qstat.room  = r_cnt < (csim_pkg::Q_AW+1)'(csim_pkg::Q_DEPTH - 1);
    assign w_pop         = i_pop && !o_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/csim_back.sv
// Back end: norm product, integer square root, division, clamp, result register.
`timescale 1ns / 1ps
`default_nettype none
module csim_back (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire csim_pkg::t_job                      i_job,
    input  wire csim_pkg::t_qstat                    i_qstat,
    output logic                                     o_pop,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [csim_pkg::FEAT_W-1:0]       o_similarity,
    output logic                                     o_zero_norm,
    output logic                                     o_length_overflow
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SQRT,
        S_DIV,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [csim_pkg::STEP_W-1:0]     r_cnt;
    logic                            r_neg;
    logic                            r_zero;
    logic                            r_ovf;
    logic [csim_pkg::DOT_W-1:0]      r_mag;
    logic [csim_pkg::NORM_W-1:0]     r_na;
    logic [csim_pkg::NORM_W-1:0]     r_nb;
    logic [63:0]                     r_pp;
    logic [1:0]                      r_pp_sh;
    logic [csim_pkg::RAD_W-1:0]      r_prod;
    logic [csim_pkg::ROOT_W-1:0]     r_root;
    logic [csim_pkg::REM_W-1:0]      r_rem;
    logic [csim_pkg::NUM_W-1:0]      r_num;
    logic [csim_pkg::DOT_W-1:0]      r_drem;
    logic [csim_pkg::NUM_W-1:0]      r_quot;
    logic                            r_out_valid;
    logic [csim_pkg::FEAT_W-1:0]     r_out_sim;
    logic                            r_out_zero;
    logic                            r_out_ovf;

    logic [31:0]                     w_op_a;
    logic [31:0]                     w_op_b;
    logic [1:0]                      w_sh;
    logic [csim_pkg::RAD_W-1:0]      w_pp_ext;
    logic [csim_pkg::REM_W-1:0]      w_rem_sh;
    logic [csim_pkg::REM_W-1:0]      w_trial;
    logic                            w_sq_ge;
    logic [csim_pkg::DOT_W-1:0]      w_drem_sh;
    logic                            w_dv_ge;
    logic [csim_pkg::FEAT_W-1:0]     w_sim;
    logic                            w_load;

    // partial products of the 41x41 norm product, operands split at bit 32
    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                w_op_a = r_na[31:0];
                w_op_b = r_nb[31:0];
                w_sh   = 2'd0;
            end
            2'd1: begin
                w_op_a = r_na[31:0];
                w_op_b = 32'(r_nb[csim_pkg::NORM_W-1:32]);
                w_sh   = 2'd1;
            end
            2'd2: begin
                w_op_a = 32'(r_na[csim_pkg::NORM_W-1:32]);
                w_op_b = r_nb[31:0];
                w_sh   = 2'd1;
            end
            default: begin
                w_op_a = 32'(r_na[csim_pkg::NORM_W-1:32]);
                w_op_b = 32'(r_nb[csim_pkg::NORM_W-1:32]);
                w_sh   = 2'd2;
            end
        endcase
    end

    assign w_pp_ext  = csim_pkg::RAD_W'(r_pp) << {r_pp_sh, 5'd0};
    assign w_rem_sh  = {r_rem[csim_pkg::REM_W-3:0],
                        r_prod[csim_pkg::RAD_W-1:csim_pkg::RAD_W-2]};
    assign w_trial   = {1'b0, r_root, 2'b01};
    assign w_sq_ge   = w_rem_sh >= w_trial;
    assign w_drem_sh = {r_drem[csim_pkg::DOT_W-2:0], r_num[csim_pkg::NUM_W-1]};
    assign w_dv_ge   = w_drem_sh >= csim_pkg::DOT_W'(r_root);

    always_comb begin
        if (r_zero) begin
            w_sim = '0;
        end else if (r_neg) begin
            if ((|r_quot[csim_pkg::NUM_W-1:16]) || (r_quot[15] && (|r_quot[14:0]))) begin
                w_sim = 16'h8000;
            end else begin
                w_sim = ~r_quot[15:0] + 16'd1;
            end
        end else if (|r_quot[csim_pkg::NUM_W-1:15]) begin
            w_sim = 16'h7fff;
        end else begin
            w_sim = {1'b0, r_quot[14:0]};
        end
    end

    assign o_pop  = (r_state == S_IDLE) && !i_qstat.empty;
    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_neg <= i_job.dot[csim_pkg::DOT_W-1];
                        r_mag <= i_job.dot[csim_pkg::DOT_W-1] ? (~i_job.dot + 1'b1)
                                                              : i_job.dot;
                        r_na   <= i_job.norm_a;
                        r_nb   <= i_job.norm_b;
                        r_ovf  <= i_job.ovf;
                        r_zero <= (i_job.norm_a == '0) || (i_job.norm_b == '0);
                        r_prod <= '0;
                        r_cnt  <= '0;
                        if ((i_job.norm_a == '0) || (i_job.norm_b == '0)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (r_cnt < csim_pkg::STEP_W'(4)) begin
                        r_pp    <= w_op_a * w_op_b;
                        r_pp_sh <= w_sh;
                    end
                    if (r_cnt != '0) begin
                        r_prod <= r_prod + w_pp_ext;
                    end
                    if (r_cnt == csim_pkg::STEP_W'(4)) begin
                        r_cnt   <= '0;
                        r_root  <= '0;
                        r_rem   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQRT: begin
                    r_prod <= r_prod << 2;
                    r_rem  <= w_sq_ge ? (w_rem_sh - w_trial) : w_rem_sh;
                    r_root <= {r_root[csim_pkg::ROOT_W-2:0], w_sq_ge};
                    if (r_cnt == csim_pkg::STEP_W'(csim_pkg::SQRT_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_num   <= {r_mag, 15'd0};
                        r_drem  <= '0;
                        r_quot  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: begin
                    r_num  <= r_num << 1;
                    r_drem <= w_dv_ge ? (w_drem_sh - csim_pkg::DOT_W'(r_root)) : w_drem_sh;
                    r_quot <= {r_quot[csim_pkg::NUM_W-2:0], w_dv_ge};
                    if (r_cnt == csim_pkg::STEP_W'(csim_pkg::DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out_sim   <= w_sim;
                r_out_zero  <= r_zero;
                r_out_ovf   <= r_ovf;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_similarity      = r_out_sim;
    assign o_zero_norm       = r_out_zero;
    assign o_length_overflow = r_out_ovf;
endmodule
`default_nettype wire

FILE: rtl/core/cosine_similarity_stream.sv
// Cosine similarity stream: top level joining front end, queue and back end.
// Input channel: i_valid/o_ready carry one element pair per word (i_feat_a,
// i_feat_b, signed Q1.15) and i_last_element marks the final pair of a vector.
// Output channel: o_valid/i_ready carry one result word per vector: the
// similarity in signed Q1.15, a zero-norm flag and a length-overflow flag.
// Pairs are taken one per cycle while the queue has room. The front end
// multiplies and accumulates in a two-stage pipeline and on the last pair hands
// the three sums to a four-entry queue. The back end works on one vector at a
// time: the 82-bit norm product from four 32x32 partial products, a bit-serial
// square root, a bit-serial division and a clamp into the result register; the
// norm product, root and divide are skipped if a norm is zero. Short vectors can
// fill the queue faster than the back end drains it, and o_ready then drops
// until the back end frees an entry. Pairs beyond MAX_ELEMENTS are dropped and
// flagged.
// Reset (synchronous, active low) empties the pipeline, queue and result
// register and clears the accumulators. A stalled receiver holds the result
// word; the back end waits with the next result and the queue keeps filling.
`timescale 1ns / 1ps
`default_nettype none
module cosine_similarity_stream (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [csim_pkg::FEAT_W-1:0]  i_feat_a,
    input  wire logic signed [csim_pkg::FEAT_W-1:0]  i_feat_b,
    input  wire logic                                i_last_element,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [csim_pkg::FEAT_W-1:0]       o_similarity,
    output logic                                     o_zero_norm,
    output logic                                     o_length_overflow
);
    logic               w_push;
    logic               w_pop;
    csim_pkg::t_job     w_in_job;
    csim_pkg::t_job     w_out_job;
    csim_pkg::t_qstat   w_qstat;

    csim_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_feat_a       (i_feat_a),
        .i_feat_b       (i_feat_b),
        .i_last_element (i_last_element),
        .i_qstat        (w_qstat),
        .o_push         (w_push),
        .o_job          (w_in_job)
    );

    csim_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .i_pop   (w_pop),
        .o_job   (w_out_job),
        .o_qstat (w_qstat)
    );

    csim_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job             (w_out_job),
        .i_qstat           (w_qstat),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_similarity      (o_similarity),
        .o_zero_norm       (o_zero_norm),
        .o_length_overflow (o_length_overflow)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("vector sums pushed into a full queue");

    a_zero_norm_sim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_norm) |-> (o_similarity == '0))
        else $error("zero-norm result with non-zero similarity");

    a_stall_has_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> !w_qstat.empty)
        else $error("input stalled with an empty queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from an empty queue");
endmodule
`default_nettype wire
